@@ rtl/ofo_pkg.sv @@
// Shared types, constants and helpers of the owned byte FIFO.
package ofo_pkg;

    // Ring geometry and field widths
    localparam int RING_DEPTH = 256;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int ID_BITS    = 16;
    localparam int CAP_W      = 9;
    localparam int BYTE_W     = 8;
    localparam int DROP_W     = 32;
    localparam int OP_W       = 3;
    // Width that holds both the capacity register and the ring depth
    localparam int EFF_W      = (CAP_W > IDX_W + 1) ? CAP_W : IDX_W + 1;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);
    localparam logic [EFF_W-1:0] MIN_PUSH_CAP = EFF_W'(2);

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH    = 3'd0,
        OP_POP     = 3'd1,
        OP_ACQUIRE = 3'd2,
        OP_RELEASE = 3'd3,
        OP_CLEAR   = 3'd4
    } op_t;

    // Result fields held between the state update and the output register
    typedef struct packed {
        logic              ok;
        logic              pop_sel;
        logic [ID_BITS-1:0] owner;
        logic              not_empty;
        logic [DROP_W-1:0] drops;
    } resp_t;

    // Capacity in use, saturated at the ring depth
    function automatic logic [EFF_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
        logic [EFF_W-1:0] c;
        c = EFF_W'(cap);
        return (c > EFF_W'(RING_DEPTH)) ? EFF_W'(RING_DEPTH) : c;
    endfunction

    // Step an index, wrapping to zero at the capacity in use
    function automatic logic [IDX_W-1:0] ring_advance(input logic [IDX_W-1:0] idx,
                                                      input logic [EFF_W-1:0] eff);
        logic [EFF_W-1:0] n;
        n = EFF_W'(idx) + EFF_W'(1);
        return (n >= eff) ? '0 : n[IDX_W-1:0];
    endfunction

endpackage

@@ rtl/ofo_if.sv @@
// Channel interfaces of the owned byte FIFO: command, result and capacity write.
interface ofo_in_if;
    logic                       valid;
    logic                       ready;
    logic [ofo_pkg::OP_W-1:0]    opcode;
    logic [ofo_pkg::ID_BITS-1:0] requester_id;
    logic [ofo_pkg::BYTE_W-1:0]  byte_value;

    modport source (output valid, opcode, requester_id, byte_value, input ready);
    modport sink   (input valid, opcode, requester_id, byte_value, output ready);
endinterface

interface ofo_out_if;
    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic [ofo_pkg::BYTE_W-1:0]  popped_byte;
    logic [ofo_pkg::ID_BITS-1:0] current_owner;
    logic                       not_empty;
    logic [ofo_pkg::DROP_W-1:0]  drop_total;

    modport source (output valid, ok, popped_byte, current_owner, not_empty, drop_total,
                    input ready);
    modport sink   (input valid, ok, popped_byte, current_owner, not_empty, drop_total,
                    output ready);
endinterface

interface ofo_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [ofo_pkg::CAP_W-1:0] capacity;

    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface

@@ rtl/ofo_ram.sv @@
// Generic single-port RAM with registered read.
module ofo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read; read data holds when idle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ofo_core.sv @@
// Command decode and state update: indices, lock, drop count, ring access.
module ofo_core (
    input  logic                        clk,
    input  logic                        rst_n,
    ofo_in_if.sink                      in_ch,
    ofo_cfg_if.sink                     cfg_ch,
    output logic                        ram_we,
    output logic                        ram_re,
    output logic [ofo_pkg::IDX_W-1:0]   ram_addr,
    output logic [ofo_pkg::BYTE_W-1:0]  ram_wdata,
    output logic                        pend_valid,
    output ofo_pkg::resp_t              pend,
    input  logic                        pend_take
);

    logic [ofo_pkg::CAP_W-1:0]   cap_reg;
    logic [ofo_pkg::IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [ofo_pkg::IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [ofo_pkg::ID_BITS-1:0] holder_reg, holder_next;
    logic [ofo_pkg::DROP_W-1:0]  drops_reg, drops_next;
    logic                        pend_valid_reg, pend_valid_next;
    ofo_pkg::resp_t              pend_reg, pend_next;

    logic [ofo_pkg::EFF_W-1:0]   eff;
    logic [ofo_pkg::IDX_W-1:0]   wr_adv, rd_adv;
    logic                        accept;
    logic                        ok;
    logic                        pop_sel;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = !pend_valid_reg || pend_take;
    assign accept       = in_ch.valid && in_ch.ready;

    assign eff    = ofo_pkg::eff_capacity(cap_reg);
    assign wr_adv = ofo_pkg::ring_advance(wr_idx_reg, eff);
    assign rd_adv = ofo_pkg::ring_advance(rd_idx_reg, eff);

    // Decode one word and work out the next state
    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        holder_next = holder_reg;
        drops_next  = drops_reg;
        ok          = 1'b0;
        pop_sel     = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_addr    = rd_idx_reg;
        ram_wdata   = in_ch.byte_value;
        if (accept)
        begin
            unique case (ofo_pkg::op_t'(in_ch.opcode))
                ofo_pkg::OP_PUSH:
                begin
                    if (eff >= ofo_pkg::MIN_PUSH_CAP && in_ch.requester_id == holder_reg)
                    begin
                        // full ring: oldest byte goes
                        if (wr_adv == rd_idx_reg)
                        begin
                            rd_idx_next = rd_adv;
                            drops_next  = drops_reg + ofo_pkg::DROP_W'(1);
                        end
                        ram_we      = 1'b1;
                        ram_addr    = wr_idx_reg;
                        wr_idx_next = wr_adv;
                        ok          = 1'b1;
                    end
                end
                ofo_pkg::OP_POP:
                begin
                    if (wr_idx_reg != rd_idx_reg)
                    begin
                        ram_re      = 1'b1;
                        rd_idx_next = rd_adv;
                        pop_sel     = 1'b1;
                        ok          = 1'b1;
                    end
                end
                ofo_pkg::OP_ACQUIRE:
                begin
                    if (in_ch.requester_id != '0 &&
                        (holder_reg == '0 || holder_reg == in_ch.requester_id))
                    begin
                        holder_next = in_ch.requester_id;
                        ok          = 1'b1;
                    end
                end
                ofo_pkg::OP_RELEASE:
                begin
                    if (in_ch.requester_id != '0 && holder_reg == in_ch.requester_id)
                    begin
                        wr_idx_next = '0;
                        rd_idx_next = '0;
                        holder_next = '0;
                        ok          = 1'b1;
                    end
                end
                ofo_pkg::OP_CLEAR:
                begin
                    wr_idx_next = '0;
                    rd_idx_next = '0;
                    ok          = 1'b1;
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase
        end
    end

    // Result held for the output stage
    always_comb
    begin
        pend_next.ok        = ok;
        pend_next.pop_sel   = pop_sel;
        pend_next.owner     = holder_next;
        pend_next.not_empty = (wr_idx_next != rd_idx_next);
        pend_next.drops     = drops_next;
        if (accept)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_take)
        begin
            pend_valid_next = 1'b0;
        end
        else
        begin
            pend_valid_next = pend_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= ofo_pkg::CAP_RESET;
            wr_idx_reg     <= '0;
            rd_idx_reg     <= '0;
            holder_reg     <= '0;
            drops_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                cap_reg <= cfg_ch.capacity;
            end
            wr_idx_reg     <= wr_idx_next;
            rd_idx_reg     <= rd_idx_next;
            holder_reg     <= holder_next;
            drops_reg      <= drops_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Pending result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= pend_next;
        end
    end

    assign pend_valid = pend_valid_reg;
    assign pend       = pend_reg;

endmodule

@@ rtl/ofo_resp.sv @@
// Output register: merges the ring read data into the result word.
module ofo_resp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pend_valid,
    input  ofo_pkg::resp_t             pend,
    input  logic [ofo_pkg::BYTE_W-1:0] ram_rdata,
    output logic                       pend_take,
    ofo_out_if.source                  out_ch
);

    logic                        out_valid_reg, out_valid_next;
    logic                        ok_reg;
    logic [ofo_pkg::BYTE_W-1:0]  byte_reg;
    logic [ofo_pkg::ID_BITS-1:0] owner_reg;
    logic                        not_empty_reg;
    logic [ofo_pkg::DROP_W-1:0]  drops_reg;
    logic                        load;

    // Output slot is free when empty or being taken
    assign pend_take = !out_valid_reg || out_ch.ready;
    assign load      = pend_valid && pend_take;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload; popped byte is zero unless a pop read the ring
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ok_reg        <= pend.ok;
            byte_reg      <= pend.pop_sel ? ram_rdata : '0;
            owner_reg     <= pend.owner;
            not_empty_reg <= pend.not_empty;
            drops_reg     <= pend.drops;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.ok            = ok_reg;
    assign out_ch.popped_byte   = byte_reg;
    assign out_ch.current_owner = owner_reg;
    assign out_ch.not_empty     = not_empty_reg;
    assign out_ch.drop_total    = drops_reg;

endmodule

@@ rtl/owned_byte_fifo_overwrite_oldest.sv @@
// Top level of the owned byte FIFO with oldest-byte overwrite.
//
// Channels: in_ch takes command words (opcode, requester_id, byte_value);
// out_ch gives one result word per command (ok, popped_byte, current_owner,
// not_empty, drop_total); cfg_ch writes the capacity register and is always
// ready. All three use valid/ready; a word moves when both are high.
// Result path: the state update, the pending result stage and the ring read
// share the accepting edge; the output register then loads from the pending
// stage once its slot is free, and only then is the result word offered.
// Throughput: one command per cycle while out_ch is ready; the single ring
// port serves either the push write or the pop read of each command.
// The output register and a pending result stage sit between the two sides,
// so a new command is taken while a result waits; when both are occupied
// and out_ch stalls, in_ch.ready drops until the receiver takes a word.
// Reset: indices, lock holder and drop count clear, capacity returns to 256,
// no result is pending. The ring contents are not cleared; the indices make
// unwritten slots unreachable.
// Capacity is to be written only with no command in flight.
module owned_byte_fifo_overwrite_oldest (
    input  logic      clk,
    input  logic      rst_n,
    ofo_in_if.sink    in_ch,
    ofo_out_if.source out_ch,
    ofo_cfg_if.sink   cfg_ch
);

    logic                       ram_we;
    logic                       ram_re;
    logic [ofo_pkg::IDX_W-1:0]  ram_addr;
    logic [ofo_pkg::BYTE_W-1:0] ram_wdata;
    logic [ofo_pkg::BYTE_W-1:0] ram_rdata;
    logic                       pend_valid;
    ofo_pkg::resp_t             pend;
    logic                       pend_take;

    // Command decode and state
    ofo_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg_ch     (cfg_ch),
        .ram_we     (ram_we),
        .ram_re     (ram_re),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .pend_valid (pend_valid),
        .pend       (pend),
        .pend_take  (pend_take)
    );

    // Byte ring
    ofo_ram #(
        .WIDTH (ofo_pkg::BYTE_W),
        .DEPTH (ofo_pkg::RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Result register
    ofo_resp u_resp (
        .clk        (clk),
        .rst_n      (rst_n),
        .pend_valid (pend_valid),
        .pend       (pend),
        .ram_rdata  (ram_rdata),
        .pend_take  (pend_take),
        .out_ch     (out_ch)
    );

endmodule

@@ rtl/ofo_checker.sv @@
// Port-level checks of the owned byte FIFO and their bind to the top level.
module ofo_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        ok,
    input logic [ofo_pkg::BYTE_W-1:0]  popped_byte,
    input logic [ofo_pkg::ID_BITS-1:0] current_owner,
    input logic                        not_empty,
    input logic [ofo_pkg::DROP_W-1:0]  drop_total
);

    // A stalled result word holds its contents
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(popped_byte) &&
        $stable(current_owner) && $stable(not_empty) && $stable(drop_total))
    else $error("result word changed while stalled");

    // A refused command never reports a popped byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> popped_byte == '0)
    else $error("popped byte set on a refused command");

    // A taken command followed by a ready receiver yields a valid result word
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready ##1 out_ready |=> out_valid)
    else $error("result missing after accepted command");

endmodule

bind owned_byte_fifo_overwrite_oldest ofo_checker u_ofo_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .ok            (out_ch.ok),
    .popped_byte   (out_ch.popped_byte),
    .current_owner (out_ch.current_owner),
    .not_empty     (out_ch.not_empty),
    .drop_total    (out_ch.drop_total)
);
